[hdl/ddo_pkg.sv]
// ----------------------------------------------------------------------------
// ddo_pkg - shared types, constants and helpers for the odometry block
// Fixed-point constants, sequencer state types, register indexes and the
// arctangent table used by the CORDIC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddo_pkg;

  // Default CORDIC iteration count
  localparam int CORDIC_STEPS = 24;

  // Angle constants, Q3.28
  localparam logic signed [33:0] Q28_PI      = 34'sd843314857;
  localparam logic signed [33:0] Q28_TWO_PI  = 34'sd1686629713;
  localparam logic signed [33:0] Q28_HALF_PI = 34'sd421657428;

  // CORDIC gain compensation, Q2.30
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN     = 1'b1;

  localparam logic [31:0] GAIN_RESET = 32'd65536;

  // Top-level sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_L,
    S_MUL_R,
    S_DIST_R,
    S_MUL_T,
    S_TURN,
    S_CORDIC,
    S_MUL_X,
    S_MUL_Y,
    S_POS_Y,
    S_OUT
  } seq_state_e;

  // CORDIC sequencer
  typedef enum logic [1:0] {
    C_IDLE,
    C_REDUCE,
    C_ITER
  } cordic_state_e;

  // Saturate a wide signed value to signed 32 bit
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // atan(2^-i) in Q3.28
  function automatic logic signed [33:0] atan_q28(input int i);
    logic signed [33:0] r;
    case (i)
      0:  r = 34'sd210828714;
      1:  r = 34'sd124459457;
      2:  r = 34'sd65760959;
      3:  r = 34'sd33381290;
      4:  r = 34'sd16755422;
      5:  r = 34'sd8385879;
      6:  r = 34'sd4193963;
      7:  r = 34'sd2097109;
      8:  r = 34'sd1048571;
      9:  r = 34'sd524287;
      10: r = 34'sd262144;
      11: r = 34'sd131072;
      12: r = 34'sd65536;
      13: r = 34'sd32768;
      14: r = 34'sd16384;
      15: r = 34'sd8192;
      16: r = 34'sd4096;
      17: r = 34'sd2048;
      18: r = 34'sd1024;
      19: r = 34'sd512;
      20: r = 34'sd256;
      21: r = 34'sd128;
      22: r = 34'sd64;
      23: r = 34'sd32;
      24: r = 34'sd16;
      25: r = 34'sd8;
      26: r = 34'sd4;
      27: r = 34'sd2;
      28: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/ddo_cordic.sv]
// ----------------------------------------------------------------------------
// ddo_cordic - iterative rotation-mode CORDIC
// Reduces an angle into [-pi, pi], folds it into [-pi/2, pi/2], then runs
// one micro-rotation per cycle to produce cosine and sine in Q2.30.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_cordic #(
  parameter int Steps = ddo_pkg::CORDIC_STEPS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [33:0] angle_i,
  output logic               done_o,
  output logic signed [32:0] cos_o,
  output logic signed [32:0] sin_o
);

  localparam int IW = (Steps > 1) ? $clog2(Steps) : 1;
  localparam logic [IW-1:0] LAST = IW'(Steps - 1);

  ddo_pkg::cordic_state_e state_q, state_d;
  logic [IW-1:0]      iter_q, iter_d;
  logic signed [33:0] ang_q, ang_d;
  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic               neg_q, neg_d;
  logic signed [32:0] cos_q, cos_d, sin_q, sin_d;
  logic               done_q, done_d;

  logic signed [33:0] x_sh, y_sh, x_nx, y_nx, z_nx, atan_v;

  // One micro-rotation
  always_comb begin
    x_sh   = x_q >>> iter_q;
    y_sh   = y_q >>> iter_q;
    atan_v = ddo_pkg::atan_q28(int'(iter_q));
    if (!z_q[33]) begin
      x_nx = x_q - y_sh;
      y_nx = y_q + x_sh;
      z_nx = z_q - atan_v;
    end else begin
      x_nx = x_q + y_sh;
      y_nx = y_q - x_sh;
      z_nx = z_q + atan_v;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    ang_d   = ang_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    neg_d   = neg_q;
    cos_d   = cos_q;
    sin_d   = sin_q;
    done_d  = 1'b0;
    unique case (state_q)
      ddo_pkg::C_IDLE: begin
        if (start_i) begin
          ang_d   = angle_i;
          state_d = ddo_pkg::C_REDUCE;
        end
      end
      ddo_pkg::C_REDUCE: begin
        if (ang_q > ddo_pkg::Q28_PI) begin
          ang_d = ang_q - ddo_pkg::Q28_TWO_PI;
        end else if (ang_q < -ddo_pkg::Q28_PI) begin
          ang_d = ang_q + ddo_pkg::Q28_TWO_PI;
        end else begin
          // fold into the right half plane
          if (ang_q > ddo_pkg::Q28_HALF_PI) begin
            z_d   = ang_q - ddo_pkg::Q28_PI;
            neg_d = 1'b1;
          end else if (ang_q < -ddo_pkg::Q28_HALF_PI) begin
            z_d   = ang_q + ddo_pkg::Q28_PI;
            neg_d = 1'b1;
          end else begin
            z_d   = ang_q;
            neg_d = 1'b0;
          end
          x_d     = ddo_pkg::CORDIC_K;
          y_d     = '0;
          iter_d  = '0;
          state_d = ddo_pkg::C_ITER;
        end
      end
      ddo_pkg::C_ITER: begin
        x_d    = x_nx;
        y_d    = y_nx;
        z_d    = z_nx;
        iter_d = iter_q + 1'b1;
        if (iter_q == LAST) begin
          cos_d   = neg_q ? 33'(-x_nx) : x_nx[32:0];
          sin_d   = neg_q ? 33'(-y_nx) : y_nx[32:0];
          done_d  = 1'b1;
          state_d = ddo_pkg::C_IDLE;
        end
      end
      default: state_d = ddo_pkg::C_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddo_pkg::C_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    ang_q  <= ang_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    neg_q  <= neg_d;
    cos_q  <= cos_d;
    sin_q  <= sin_d;
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

`ifndef ASSERT_OFF
  // done only follows the last iteration
  a_done_after_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ddo_pkg::C_ITER))
    else $error("cordic done without iteration");
  // a start is only issued while idle
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == ddo_pkg::C_IDLE)
    else $error("cordic started while busy");
  // the iteration counter never passes the last step
  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ddo_pkg::C_ITER |-> iter_q <= LAST)
    else $error("cordic iteration overrun");
`endif

endmodule

[hdl/differential_drive_odometry_top.sv]
// ----------------------------------------------------------------------------
// differential_drive_odometry_top - differential-drive dead reckoning
// Scales wheel speeds to distances, derives turn and forward step, and
// advances the pose along the midpoint heading using a CORDIC.
// ----------------------------------------------------------------------------
// A wheel-speed beat is accepted in the idle state and then steps through
// the gain and turn multiplies on a single shared 33x33 multiplier (states
// MUL_L, MUL_R, DIST_R, MUL_T, TURN), the heading range reduction and the
// CORDIC run at one micro-rotation per cycle, which then hands back cosine
// and sine, the two position multiplies and the pose update (MUL_X, MUL_Y,
// POS_Y), and the load of the output register (OUT), before it returns to
// idle, where the next beat is taken. The input is not ready while a beat
// is in work. A finished result sits in an output register, so the next
// beat may be taken while it waits; the block then holds in its last step
// only if the previous result is still untaken. Configuration writes are
// always taken and must arrive only while the block is idle.
`timescale 1ns / 1ps

module differential_drive_odometry_top #(
  parameter int CordicSteps = ddo_pkg::CORDIC_STEPS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  // wheel speed channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [15:0]           left_speed_i,
  input  logic signed [15:0]           right_speed_i,
  // pose channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           x_out_o,
  output logic signed [31:0]           y_out_o,
  output logic signed [31:0]           heading_out_o,
  output logic signed [31:0]           distance_step_o,
  output logic signed [31:0]           turn_step_o
);

  ddo_pkg::seq_state_e state_q, state_d;

  logic [31:0]        dist_gain_q, turn_gain_q;
  logic signed [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d, head_q, head_d;
  logic signed [15:0] ls_q, ls_d, rs_q, rs_d;
  logic signed [31:0] dl_q, dl_d, dr_q, dr_d, step_q, step_d, turn_q, turn_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] xo_q, xo_d, yo_q, yo_d, ho_q, ho_d, so_q, so_d, to_q, to_d;

  // shared multiplier
  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod_q;

  logic               crd_start, crd_done;
  logic signed [33:0] crd_angle;
  logic signed [32:0] crd_cos, crd_sin;

  logic signed [31:0] dist_w, turn_w, diff_w;
  logic signed [33:0] head_sum;
  logic signed [65:0] pos_sum;

  ddo_cordic #(
    .Steps(CordicSteps)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(crd_start),
    .angle_i(crd_angle),
    .done_o (crd_done),
    .cos_o  (crd_cos),
    .sin_o  (crd_sin)
  );

  // Product post-processing
  always_comb begin
    dist_w   = ddo_pkg::sat32(prod_q >>> 6);
    turn_w   = ddo_pkg::sat32(prod_q >>> 4);
    diff_w   = ddo_pkg::sat32(66'(dr_q) - 66'(dl_q));
    head_sum = 34'(head_q) + 34'(turn_q);
    crd_angle = 34'(head_q) + 34'(turn_w >>> 1);
  end

  // Sequencer and datapath
  always_comb begin
    state_d     = state_q;
    ls_d        = ls_q;
    rs_d        = rs_q;
    dl_d        = dl_q;
    dr_d        = dr_q;
    step_d      = step_q;
    turn_d      = turn_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    head_d      = head_q;
    xo_d        = xo_q;
    yo_d        = yo_q;
    ho_d        = ho_q;
    so_d        = so_q;
    to_d        = to_q;
    out_valid_d = out_valid_q && !out_ready_i;
    op_a        = 33'(ls_q);
    op_b        = $signed({1'b0, dist_gain_q});
    crd_start   = 1'b0;
    pos_sum     = '0;
    unique case (state_q)
      ddo_pkg::S_IDLE: begin
        if (in_valid_i) begin
          ls_d    = left_speed_i;
          rs_d    = right_speed_i;
          state_d = ddo_pkg::S_MUL_L;
        end
      end
      ddo_pkg::S_MUL_L: begin
        state_d = ddo_pkg::S_MUL_R;
      end
      ddo_pkg::S_MUL_R: begin
        dl_d    = dist_w;
        op_a    = 33'(rs_q);
        state_d = ddo_pkg::S_DIST_R;
      end
      ddo_pkg::S_DIST_R: begin
        dr_d    = dist_w;
        state_d = ddo_pkg::S_MUL_T;
      end
      ddo_pkg::S_MUL_T: begin
        op_a    = 33'(diff_w);
        op_b    = $signed({1'b0, turn_gain_q});
        step_d  = 32'((33'(dl_q) + 33'(dr_q)) >>> 1);
        state_d = ddo_pkg::S_TURN;
      end
      ddo_pkg::S_TURN: begin
        turn_d    = turn_w;
        crd_start = 1'b1;
        state_d   = ddo_pkg::S_CORDIC;
      end
      ddo_pkg::S_CORDIC: begin
        if (crd_done) begin
          state_d = ddo_pkg::S_MUL_X;
        end
      end
      ddo_pkg::S_MUL_X: begin
        op_a    = 33'(step_q);
        op_b    = crd_cos;
        state_d = ddo_pkg::S_MUL_Y;
      end
      ddo_pkg::S_MUL_Y: begin
        pos_sum = 66'(pos_x_q) + (prod_q >>> 30);
        pos_x_d = ddo_pkg::sat32(pos_sum);
        op_a    = 33'(step_q);
        op_b    = crd_sin;
        state_d = ddo_pkg::S_POS_Y;
      end
      ddo_pkg::S_POS_Y: begin
        pos_sum = 66'(pos_y_q) + (prod_q >>> 30);
        pos_y_d = ddo_pkg::sat32(pos_sum);
        // single wrap by 2*pi, then saturate
        if (head_sum >= ddo_pkg::Q28_TWO_PI) begin
          head_d = ddo_pkg::sat32(66'(head_sum - ddo_pkg::Q28_TWO_PI));
        end else if (head_sum <= -ddo_pkg::Q28_TWO_PI) begin
          head_d = ddo_pkg::sat32(66'(head_sum + ddo_pkg::Q28_TWO_PI));
        end else begin
          head_d = ddo_pkg::sat32(66'(head_sum));
        end
        state_d = ddo_pkg::S_OUT;
      end
      ddo_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          xo_d        = pos_x_q;
          yo_d        = pos_y_q;
          ho_d        = head_q;
          so_d        = step_q;
          to_d        = turn_q;
          out_valid_d = 1'b1;
          state_d     = ddo_pkg::S_IDLE;
        end
      end
      default: state_d = ddo_pkg::S_IDLE;
    endcase
  end

  // Control and pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ddo_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      head_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      head_q      <= head_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_gain_q <= ddo_pkg::GAIN_RESET;
      turn_gain_q <= ddo_pkg::GAIN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ddo_pkg::REG_DISTANCE_GAIN: dist_gain_q <= cfg_data_i;
        ddo_pkg::REG_TURN_GAIN:     turn_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Payload registers and the shared multiplier
  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    ls_q   <= ls_d;
    rs_q   <= rs_d;
    dl_q   <= dl_d;
    dr_q   <= dr_d;
    step_q <= step_d;
    turn_q <= turn_d;
    xo_q   <= xo_d;
    yo_q   <= yo_d;
    ho_q   <= ho_d;
    so_q   <= so_d;
    to_q   <= to_d;
  end

  assign cfg_ready_o     = 1'b1;
  assign in_ready_o      = (state_q == ddo_pkg::S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign x_out_o         = xo_q;
  assign y_out_o         = yo_q;
  assign heading_out_o   = ho_q;
  assign distance_step_o = so_q;
  assign turn_step_o     = to_q;

`ifndef ASSERT_OFF
  // an accepted beat starts the sequence
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ddo_pkg::S_MUL_L)
    else $error("accepted beat did not start the sequence");
  // cordic completion moves on to the position multiplies
  a_cordic_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ddo_pkg::S_CORDIC && crd_done) |=> state_q == ddo_pkg::S_MUL_X)
    else $error("cordic result not consumed");
  // the cordic is started exactly once per beat
  a_cordic_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crd_start |=> state_q == ddo_pkg::S_CORDIC)
    else $error("cordic start out of sequence");
  // leaving the output step always leaves a result pending
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ddo_pkg::S_OUT && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("result not presented");
`endif

endmodule

[bench/odometry_checker.sv]
// ----------------------------------------------------------------------------
// odometry_checker - pose predictor and result scoreboard
// Watches the configuration, wheel speed and pose channels of the odometry
// block, keeps its own copy of the gains and the pose, predicts every pose
// beat and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module odometry_checker #(
  parameter int CordicSteps = ddo_pkg::CORDIC_STEPS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [15:0]            left_speed_i,
  input  logic signed [15:0]            right_speed_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [31:0]            x_out_i,
  input  logic signed [31:0]            y_out_i,
  input  logic signed [31:0]            heading_out_i,
  input  logic signed [31:0]            distance_step_i,
  input  logic signed [31:0]            turn_step_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  // angle constants, Q3.28
  localparam longint PiQ28     = 64'sd843314857;
  localparam longint TwoPiQ28  = 64'sd1686629713;
  localparam longint HalfPiQ28 = 64'sd421657428;
  // CORDIC start vector length, Q2.30
  localparam longint UnitGainQ30 = 64'sd652032874;
  localparam int     AtanDepth   = 30;
  localparam int     Rotations   = (CordicSteps > AtanDepth) ? AtanDepth : CordicSteps;
  localparam int     ReportLimit = 10;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] heading;
    logic signed [31:0] distance;
    logic signed [31:0] turn;
  } pose_t;

  // atan(2^-i), Q3.28
  longint atan_table [AtanDepth] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
    2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0
  };

  logic [31:0]        dist_gain;
  logic [31:0]        rot_gain;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading_q;

  pose_t pose_queue [$];
  pose_t predicted;
  pose_t oldest;
  int    mismatches;

  function automatic longint clamp32(input longint v);
    longint r;
    if (v > 64'sd2147483647) begin
      r = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      r = -64'sd2147483648;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // one odometry tick from the current gains and pose
  function automatic pose_t odometry_step(input logic signed [15:0] left_spd,
                                          input logic signed [15:0] right_spd);
    longint ls, rs, dg, tg, dl, dr, diff, turn, step, ang;
    longint cx, cy, cz, xs, ys, hnew;
    bit     flip;
    int     i;
    pose_t  r;
    ls   = longint'(left_spd);
    rs   = longint'(right_spd);
    dg   = longint'({32'h0, dist_gain});
    tg   = longint'({32'h0, rot_gain});
    dl   = clamp32((ls * dg) >>> 6);
    dr   = clamp32((rs * dg) >>> 6);
    diff = clamp32(dr - dl);
    turn = clamp32((diff * tg) >>> 4);
    step = (dl + dr) >>> 1;
    // midpoint heading into [-pi, pi], then folded into [-pi/2, pi/2]
    ang  = longint'(heading_q) + (turn >>> 1);
    while (ang > PiQ28) ang = ang - TwoPiQ28;
    while (ang < -PiQ28) ang = ang + TwoPiQ28;
    flip = 1'b0;
    if (ang > HalfPiQ28) begin
      ang  = ang - PiQ28;
      flip = 1'b1;
    end else if (ang < -HalfPiQ28) begin
      ang  = ang + PiQ28;
      flip = 1'b1;
    end
    // rotation-mode CORDIC
    cx = UnitGainQ30;
    cy = 0;
    cz = ang;
    for (i = 0; i < Rotations; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cz >= 0) begin
        cx = cx - ys;
        cy = cy + xs;
        cz = cz - atan_table[i];
      end else begin
        cx = cx + ys;
        cy = cy - xs;
        cz = cz + atan_table[i];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    r.x = 32'(clamp32(longint'(pos_x) + ((step * cx) >>> 30)));
    r.y = 32'(clamp32(longint'(pos_y) + ((step * cy) >>> 30)));
    // single wrap by 2*pi
    hnew = longint'(heading_q) + turn;
    if (hnew >= TwoPiQ28) begin
      hnew = hnew - TwoPiQ28;
    end else if (hnew <= -TwoPiQ28) begin
      hnew = hnew + TwoPiQ28;
    end
    r.heading  = 32'(clamp32(hnew));
    r.distance = 32'(step);
    r.turn     = 32'(turn);
    return r;
  endfunction

  // scoreboard: retire the oldest pose first, then queue the new prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_gain    = ddo_pkg::GAIN_RESET;
      rot_gain     = ddo_pkg::GAIN_RESET;
      pos_x        = '0;
      pos_y        = '0;
      heading_q    = '0;
      mismatches   = 0;
      pose_queue.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ddo_pkg::REG_DISTANCE_GAIN: dist_gain = cfg_data_i;
          ddo_pkg::REG_TURN_GAIN:     rot_gain  = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pose_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t: pose beat with nothing outstanding: x=%0d y=%0d h=%0d",
                     $realtime, x_out_i, y_out_i, heading_out_i);
          end
        end else begin
          oldest = pose_queue.pop_front();
          if (oldest.x !== x_out_i || oldest.y !== y_out_i
              || oldest.heading !== heading_out_i
              || oldest.distance !== distance_step_i
              || oldest.turn !== turn_step_i) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("%0t: pose mismatch", $realtime);
              $display("  x        exp %0d got %0d", oldest.x, x_out_i);
              $display("  y        exp %0d got %0d", oldest.y, y_out_i);
              $display("  heading  exp %0d got %0d", oldest.heading, heading_out_i);
              $display("  distance exp %0d got %0d", oldest.distance, distance_step_i);
              $display("  turn     exp %0d got %0d", oldest.turn, turn_step_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted = odometry_step(left_speed_i, right_speed_i);
        pos_x     = predicted.x;
        pos_y     = predicted.y;
        heading_q = predicted.heading;
        pose_queue.insert(pose_queue.size(), predicted);
      end
      fail_count_o <= mismatches;
      pending_o    <= pose_queue.size();
    end
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for the odometry block
// Drives wheel speed beats and gain writes over several gain settings,
// with random idling on both sides and one long output hold-off; the
// checker beside the block predicts and compares every pose beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int Latency    = ddo_pkg::CORDIC_STEPS + 15;
  localparam int StallLimit = 5000;
  localparam int HoldCycles = 400;
  localparam int HoldAfter  = 80;
  localparam int Phases     = 7;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]                   cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [15:0]            left_speed_i;
  logic signed [15:0]            right_speed_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [31:0]            x_out_o;
  logic signed [31:0]            y_out_o;
  logic signed [31:0]            heading_out_o;
  logic signed [31:0]            distance_step_o;
  logic signed [31:0]            turn_step_o;

  int fail_count;
  int pending;
  int pose_beats = 0;
  int quiet_cycles = 0;
  bit steady;
  bit held_off;

  differential_drive_odometry_top DUT (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .left_speed_i, .right_speed_i,
    .out_valid_o, .out_ready_i,
    .x_out_o, .y_out_o, .heading_out_o, .distance_step_o, .turn_step_o
  );

  odometry_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .left_speed_i, .right_speed_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .x_out_i(x_out_o), .y_out_i(y_out_o), .heading_out_i(heading_out_o),
    .distance_step_i(distance_step_o), .turn_step_i(turn_step_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on channel activity, also counts pose beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) pose_beats++;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
          || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("differential_drive_odometry_top verification failed");
        $finish;
      end
    end
  end

  // pose receiver: random idling, one long hold-off to back up the block
  initial begin
    out_ready_i = 1'b0;
    held_off    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && pose_beats >= HoldAfter) begin
        held_off    = 1'b1;
        out_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        out_ready_i = steady || ($urandom_range(0, 99) >= 38);
      end
    end
  end

  // one gain write beat; enters and leaves at a falling edge
  task automatic write_gain(input logic [ddo_pkg::CFG_IDX_W-1:0] idx,
                            input logic [31:0] value);
    while ($urandom_range(0, 99) < 38) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // one wheel speed beat; valid stays high for a back-to-back follower
  task automatic send_speeds(input logic signed [15:0] l, input logic signed [15:0] r);
    while (!steady && $urandom_range(0, 99) < 38) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    left_speed_i  = l;
    right_speed_i = r;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_poses();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] corner_speed();
    logic signed [15:0] v;
    case ($urandom_range(0, 4))
      0: v = 16'sh7FFF;
      1: v = 16'sh8000;
      2: v = 16'sh0000;
      3: v = 16'shFFFF;
      default: v = 16'sh0001;
    endcase
    return v;
  endfunction

  // random speed pair: mostly small drives, some full range, straight and spin
  task automatic random_speeds(output logic signed [15:0] l, output logic signed [15:0] r);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      l = 16'($urandom_range(0, 511)) - 16'sd256;
      r = 16'($urandom_range(0, 511)) - 16'sd256;
    end else if (sel < 65) begin
      l = 16'($urandom);
      r = 16'($urandom);
    end else if (sel < 80) begin
      l = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 511)) - 16'sd256;
      r = l;
    end else if (sel < 92) begin
      l = 16'($urandom_range(0, 1023)) - 16'sd512;
      r = -l;
    end else begin
      l = corner_speed();
      r = corner_speed();
    end
  endtask

  logic signed [15:0] dir_left  [20] = '{
    0, 32767, -32768, 32767, -32768, -1, 1,
    0, 0, 0, 0, 0,
    100, 100, 100, 100, 100, 100,
    -1, 0
  };
  logic signed [15:0] dir_right [20] = '{
    0, 32767, -32768, -32768, 32767, -1, 1,
    100, 100, 100, 100, 100,
    0, 0, 0, 0, 0, 0,
    0, -1
  };

  initial begin
    int                 p, k, count;
    logic [31:0]        dgain, tgain;
    logic signed [15:0] l, r;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = ddo_pkg::REG_DISTANCE_GAIN;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    left_speed_i  = '0;
    right_speed_i = '0;
    steady        = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, spins both ways, heading wrap up and down
    for (k = 0; k < 20; k++) send_speeds(dir_left[k], dir_right[k]);
    drain_poses();

    // random phases over several gain settings, extremes included
    for (p = 0; p < Phases; p++) begin
      case (p)
        0: begin dgain = 32'd65536;    tgain = 32'd65536;    count = 260; end
        1: begin dgain = 32'hFFFFFFFF; tgain = 32'hFFFFFFFF; count = 60;  end
        2: begin dgain = 32'd0;        tgain = 32'd0;        count = 40;  end
        3: begin dgain = 32'd0;        tgain = 32'hFFFFFFFF; count = 30;  end
        4: begin dgain = 32'hFFFFFFFF; tgain = 32'd0;        count = 30;  end
        5: begin dgain = $urandom;     tgain = $urandom;     count = 120; end
        default: begin
          dgain = $urandom_range(1, 32'h40000);
          tgain = $urandom_range(1, 32'h80000);
          count = 400;
        end
      endcase
      write_gain(ddo_pkg::REG_DISTANCE_GAIN, dgain);
      write_gain(ddo_pkg::REG_TURN_GAIN, tgain);
      for (k = 0; k < count; k++) begin
        steady = (p == Phases - 1) && (k >= 100) && (k < 250);
        random_speeds(l, r);
        send_speeds(l, r);
      end
      steady = 1'b0;
      drain_poses();
    end

    // let any stray beat show up before the verdict
    repeat (2 * Latency) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("differential_drive_odometry_top verification clean");
    end else begin
      $display("differential_drive_odometry_top verification failed");
    end
    $finish;
  end

endmodule
